// File: design/fasc_pkg.sv
// Shared types and constants for the second-chance frame allocator.
// Holds beat structs, op codes and status codes; depends on nothing.
`default_nettype none

package fasc_pkg;

    localparam int NUM_FRAMES   = 64;
    localparam int FRAME_BITS   = $clog2(NUM_FRAMES);
    localparam int CNT_BITS     = FRAME_BITS + 1;
    localparam int PAGE_ID_BITS = 20;
    localparam int OP_BITS      = 3;
    localparam int STATUS_BITS  = 2;

    localparam logic [OP_BITS-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_BITS-1:0] OP_TOUCH   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_PIN     = 3'd3;
    localparam logic [OP_BITS-1:0] OP_VICTIM  = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_VICTIM = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]      op;
        logic [FRAME_BITS-1:0]   frame_index;
        logic [PAGE_ID_BITS-1:0] page_id;
        logic                    pin_value;
    } in_beat_t;

    typedef struct packed {
        logic                    ok;
        logic [STATUS_BITS-1:0]  status;
        logic [FRAME_BITS-1:0]   result_frame;
        logic [PAGE_ID_BITS-1:0] result_page;
    } out_beat_t;

endpackage

`default_nettype wire

// File: design/frame_alloc_second_chance.sv
// Top level of the second-chance frame allocator: frame table, scan sequencer, APB port.
// Depends on fasc_pkg for beat types, op codes and status codes.
// Release, touch, pin and unknown ops are settled at the accept and need no table scan.
// Allocate scans up to the first free frame; victim selection runs up to two passes
// over the managed frames, one frame checked per scan cycle.
// One beat at a time: s_ready is high only when the sequencer is idle.
// Reset: every frame free, accessed and pin bits clear, frames_in_use 64; owners not cleared.
`default_nettype none

module frame_alloc_second_chance
    import fasc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    // input channel
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    // result channel
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;   // wait for an input beat
    localparam logic [1:0] S_SCAN  = 2'd1;   // walk the table one frame per cycle
    localparam logic [1:0] S_FETCH = 2'd2;   // owner read of the victim is in flight
    localparam logic [1:0] S_OUT   = 2'd3;   // hand the result to the output register

    logic [1:0]              state_reg, state_next;
    logic [CNT_BITS-1:0]     frames_reg;
    logic [NUM_FRAMES-1:0]   used_reg, used_next;
    logic [NUM_FRAMES-1:0]   acc_reg, acc_next;
    logic [NUM_FRAMES-1:0]   pin_reg, pin_next;
    logic [CNT_BITS-1:0]     pos_reg, pos_next;
    logic                    pass_reg, pass_next;
    logic [OP_BITS-1:0]      op_reg, op_next;
    logic [PAGE_ID_BITS-1:0] page_reg, page_next;
    out_beat_t               res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    out_beat_t               m_data_reg, m_data_next;

    // Owner store: one write and one registered read per cycle, both at the scan position
    logic [PAGE_ID_BITS-1:0] owner_mem [NUM_FRAMES];
    logic [PAGE_ID_BITS-1:0] owner_q;
    logic                    own_we;

    logic [CNT_BITS-1:0]     limit;
    logic [FRAME_BITS-1:0]   cur;
    logic                    cfg_wr;

    // Managed count saturates at the table size
    assign limit = (frames_reg > CNT_BITS'(NUM_FRAMES)) ? CNT_BITS'(NUM_FRAMES) : frames_reg;
    assign cur   = pos_reg[FRAME_BITS-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // APB: register 0 at byte address 0, anything with paddr[2] set is unmapped
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32 - CNT_BITS){1'b0}}, frames_reg};

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        acc_next     = acc_reg;
        pin_next     = pin_reg;
        pos_next     = pos_reg;
        pass_next    = pass_reg;
        op_next      = op_reg;
        page_next    = page_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        own_we       = 1'b0;

        // drop the output beat once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_data.op;
                    page_next = s_data.page_id;
                    pos_next  = '0;
                    pass_next = 1'b0;
                    res_next  = '0;
                    unique case (s_data.op) inside
                        OP_ALLOC, OP_VICTIM: begin
                            state_next = S_SCAN;
                        end
                        OP_RELEASE, OP_TOUCH, OP_PIN: begin
                            // single-frame ops finish at the accept edge
                            if ({1'b0, s_data.frame_index} >= limit) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                res_next.ok = 1'b1;
                                if (s_data.op == OP_RELEASE) begin
                                    used_next[s_data.frame_index] = 1'b0;
                                end else if (s_data.op == OP_TOUCH) begin
                                    acc_next[s_data.frame_index] = 1'b1;
                                end else begin
                                    pin_next[s_data.frame_index] = s_data.pin_value;
                                end
                            end
                            state_next = S_OUT;
                        end
                        default: begin
                            res_next.status = ST_RANGE;
                            state_next      = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (pos_reg >= limit) begin
                    // end of one pass over the managed frames
                    if (op_reg == OP_ALLOC) begin
                        res_next.status = ST_NO_FREE;
                        state_next      = S_OUT;
                    end else if (!pass_reg) begin
                        pass_next = 1'b1;
                        pos_next  = '0;
                    end else begin
                        res_next.status = ST_NO_VICTIM;
                        state_next      = S_OUT;
                    end
                end else if (op_reg == OP_ALLOC) begin
                    if (!used_reg[cur]) begin
                        // grant the first free frame and give it a clean slate
                        own_we                = 1'b1;
                        used_next[cur]        = 1'b1;
                        acc_next[cur]         = 1'b0;
                        pin_next[cur]         = 1'b0;
                        res_next.ok           = 1'b1;
                        res_next.result_frame = cur;
                        state_next            = S_OUT;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end else begin
                    if (used_reg[cur] && !pin_reg[cur] && !acc_reg[cur]) begin
                        // victim found: hold the position while the owner read lands
                        res_next.ok           = 1'b1;
                        res_next.result_frame = cur;
                        state_next            = S_FETCH;
                    end else begin
                        // second chance: clear the accessed bit of a used, unpinned frame passed over
                        if (used_reg[cur] && !pin_reg[cur]) begin
                            acc_next[cur] = 1'b0;
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_FETCH: begin
                res_next.result_page = owner_q;
                state_next           = S_OUT;
            end
            S_OUT: begin
                // advance only when the output register is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            frames_reg  <= CNT_BITS'(NUM_FRAMES);
            used_reg    <= '0;
            acc_reg     <= '0;
            pin_reg     <= '0;
            pos_reg     <= '0;
            pass_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            acc_reg     <= acc_next;
            pin_reg     <= pin_next;
            pos_reg     <= pos_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                frames_reg <= pwdata[CNT_BITS-1:0];
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        page_reg   <= page_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (own_we) begin
            owner_mem[cur] <= page_reg;
        end
        owner_q <= owner_mem[cur];
    end

endmodule

`default_nettype wire

// File: design/fasc_checker.sv
// Port-level checker for the second-chance frame allocator, bound to the top level.
// Depends on fasc_pkg for the beat types and status codes.
`default_nettype none

module fasc_checker
    import fasc_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_beat_t m_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // One item at a time: no new beat right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // Success always carries status ok
    a_ok_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ok |-> m_data.status == ST_OK)
        else $error("ok with failing status");

    // Failures carry no frame and no page
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ok |-> m_data.status != ST_OK && m_data.result_frame == '0
                                  && m_data.result_page == '0)
        else $error("failure with nonzero payload");

endmodule

bind frame_alloc_second_chance fasc_checker u_fasc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: test/tb.sv
// Self-checking bench for frame_alloc_second_chance: beats in, answers out, APB setup.
// Depends on fasc_pkg for beat structs, op codes, status codes and table sizes.
// Predicts every answer from a private copy of the frame table and checks it field by field.
`default_nettype none

module tb;
    import fasc_pkg::*;

    // Register map: frames_in_use is register 0, so byte address 0.
    localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;

    // Op codes the block does not define; it must answer them with a range status.
    localparam logic [OP_BITS-1:0] OP_BAD_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_BAD_HI = 3'd7;

    // Settle time after the last answer, with margin beyond the longest victim scan.
    localparam int SETTLE_CYCLES = 150;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Private copy of the frame table. Owners of never-allocated frames are
    // never read, since a victim scan only picks used frames.
    bit                      tbl_used     [NUM_FRAMES];
    logic [PAGE_ID_BITS-1:0] tbl_owner    [NUM_FRAMES];
    bit                      tbl_accessed [NUM_FRAMES];
    bit                      tbl_pinned   [NUM_FRAMES];
    logic [CNT_BITS-1:0]     tbl_count;

    in_beat_t  req_q[$];     // requests waiting to be driven
    out_beat_t answer_q[$];  // predicted answers, oldest first

    int reqs_sent;
    int reqs_taken;
    int mismatches;
    int send_gap;
    int recv_stall;
    int send_idle_pct;
    int recv_stall_pct;

    frame_alloc_second_chance uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the table copy and return the answer it must produce.
    function automatic out_beat_t frame_table_step(in_beat_t b);
        out_beat_t r;
        int        lim;
        int        pass;
        int        f;
        bit        done;
        r    = '0;
        done = 1'b0;
        // Counts above the table size saturate.
        lim  = (tbl_count > NUM_FRAMES) ? NUM_FRAMES : int'(tbl_count);
        case (b.op)
            OP_ALLOC: begin
                // Lowest free frame wins; its accessed and pin bits start clear.
                r.status = ST_NO_FREE;
                for (f = 0; f < lim && !done; f++) begin
                    if (!tbl_used[f]) begin
                        tbl_owner[f]    = b.page_id;
                        tbl_used[f]     = 1'b1;
                        tbl_accessed[f] = 1'b0;
                        tbl_pinned[f]   = 1'b0;
                        r.ok            = 1'b1;
                        r.status        = ST_OK;
                        r.result_frame  = FRAME_BITS'(f);
                        done            = 1'b1;
                    end
                end
            end
            OP_RELEASE, OP_TOUCH, OP_PIN: begin
                // Free frames may be released, touched or pinned; unmanaged ones may not.
                if (int'(b.frame_index) >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    if (b.op == OP_RELEASE)
                        tbl_used[b.frame_index] = 1'b0;
                    else if (b.op == OP_TOUCH)
                        tbl_accessed[b.frame_index] = 1'b1;
                    else
                        tbl_pinned[b.frame_index] = b.pin_value;
                    r.ok     = 1'b1;
                    r.status = ST_OK;
                end
            end
            OP_VICTIM: begin
                // Two passes from frame 0: skip free or pinned frames, give accessed
                // frames a second chance by clearing the bit, stop at the first clear one.
                r.status = ST_NO_VICTIM;
                for (pass = 0; pass < 2 && !done; pass++) begin
                    for (f = 0; f < lim && !done; f++) begin
                        if (tbl_used[f] && !tbl_pinned[f]) begin
                            if (!tbl_accessed[f]) begin
                                r.ok           = 1'b1;
                                r.status       = ST_OK;
                                r.result_frame = FRAME_BITS'(f);
                                r.result_page  = tbl_owner[f];
                                done           = 1'b1;
                            end else begin
                                tbl_accessed[f] = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_beat_t make_req(logic [OP_BITS-1:0] op, int frame,
                                          logic [PAGE_ID_BITS-1:0] page, logic pin);
        in_beat_t b;
        b.op          = op;
        b.frame_index = FRAME_BITS'(frame);
        b.page_id     = page;
        b.pin_value   = pin;
        return b;
    endfunction

    // Random request with content aimed at the managed frames most of the time.
    function automatic in_beat_t random_req(int lim);
        in_beat_t b;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 26)
            b.op = OP_ALLOC;
        else if (pick < 42)
            b.op = OP_RELEASE;
        else if (pick < 64)
            b.op = OP_TOUCH;
        else if (pick < 79)
            b.op = OP_PIN;
        else if (pick < 97)
            b.op = OP_VICTIM;
        else
            b.op = OP_BITS'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        if (lim > 0 && $urandom_range(0, 99) < 88)
            b.frame_index = FRAME_BITS'($urandom_range(0, lim - 1));
        else
            b.frame_index = FRAME_BITS'($urandom);
        b.page_id   = PAGE_ID_BITS'($urandom);
        b.pin_value = 1'($urandom_range(0, 1));
        return b;
    endfunction

    task automatic send(in_beat_t b);
        req_q.push_back(b);
        reqs_sent++;
    endtask

    // Hold until every request is taken and every answer has come back.
    task automatic drain();
        while (reqs_taken != reqs_sent || answer_q.size() != 0)
            @(posedge aclk);
    endtask

    // APB write of frames_in_use: setup beat, then access until pready.
    // Call only with the block idle.
    task automatic write_frames(logic [CNT_BITS-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FRAMES_IN_USE;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tbl_count = value;
    endtask

    // Request driver: take the beat on a handshake, predict its answer, then
    // either hold, idle for a while, or present the next queued request.
    always @(posedge aclk) begin : req_driver
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                answer_q.push_back(frame_table_step(s_data));
                reqs_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (req_q.size() != 0) begin
                    s_data  <= req_q.pop_front();
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 99) < send_idle_pct)
                        send_gap <= idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Answer checker: compare each accepted answer with the oldest prediction,
    // and throttle m_ready with random stalls.
    always @(posedge aclk) begin : answer_check
        out_beat_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: answer with nothing pending: ok %0d status %0d frame %0d page %h",
                                 m_data.ok, m_data.status, m_data.result_frame,
                                 m_data.result_page);
                end else begin
                    want = answer_q.pop_front();
                    if (m_data.ok !== want.ok || m_data.status !== want.status ||
                        m_data.result_frame !== want.result_frame ||
                        m_data.result_page !== want.result_page) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"tb: answer mismatch: expected ok %0d status %0d frame %0d",
                                      " page %h, got ok %0d status %0d frame %0d page %h"},
                                     want.ok, want.status, want.result_frame,
                                     want.result_page, m_data.ok, m_data.status,
                                     m_data.result_frame, m_data.result_page);
                    end
                end
            end
            if (recv_stall != 0) begin
                m_ready    <= 1'b0;
                recv_stall <= recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < recv_stall_pct)
                    recv_stall <= idle_len();
            end
        end
    end

    initial begin : stimulus
        int                  p;
        int                  k;
        int                  n;
        int                  lim;
        logic [CNT_BITS-1:0] cfg;

        // Drive every input to a known value before the first edge.
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        reqs_sent      = 0;
        reqs_taken     = 0;
        mismatches     = 0;
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        tbl_count      = CNT_BITS'(NUM_FRAMES);
        for (k = 0; k < NUM_FRAMES; k++) begin
            tbl_used[k]     = 1'b0;
            tbl_owner[k]    = '0;
            tbl_accessed[k] = 1'b0;
            tbl_pinned[k]   = 1'b0;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset count of 64 frames.
        send(make_req(OP_VICTIM, 0, '0, 1'b0));         // empty table: no victim
        send(make_req(OP_RELEASE, 0, '0, 1'b0));        // release of a free frame
        send(make_req(OP_TOUCH, 5, '0, 1'b0));          // touch a free frame
        send(make_req(OP_PIN, 6, '0, 1'b1));            // pin a free frame
        send(make_req(OP_ALLOC, 0, 20'hFFFFF, 1'b0));
        send(make_req(OP_ALLOC, 63, 20'h00000, 1'b1));
        send(make_req(OP_ALLOC, 0, 20'h12345, 1'b0));
        send(make_req(OP_ALLOC, 0, 20'hABCDE, 1'b0));
        send(make_req(OP_ALLOC, 0, 20'h00001, 1'b0));
        send(make_req(OP_ALLOC, 0, 20'h80000, 1'b0));   // frame 5: touch bit cleared
        send(make_req(OP_ALLOC, 0, 20'h7FFFF, 1'b0));   // frame 6: pin bit cleared
        send(make_req(OP_VICTIM, 0, '0, 1'b0));
        send(make_req(OP_TOUCH, 0, '0, 1'b0));
        send(make_req(OP_TOUCH, 1, '0, 1'b0));
        send(make_req(OP_PIN, 2, '0, 1'b1));
        send(make_req(OP_VICTIM, 0, '0, 1'b0));         // second chance for 0 and 1, 2 pinned
        send(make_req(OP_BAD_HI, 63, 20'hFFFFF, 1'b1)); // undefined op
        send(make_req(OP_RELEASE, 63, '0, 1'b0));
        drain();

        // No frames managed: every op fails.
        write_frames(CNT_BITS'(0));
        send(make_req(OP_ALLOC, 0, 20'h55555, 1'b0));
        send(make_req(OP_TOUCH, 0, '0, 1'b0));
        send(make_req(OP_VICTIM, 0, '0, 1'b0));
        drain();

        // Count above the table size saturates at 64.
        write_frames(CNT_BITS'(127));
        send(make_req(OP_TOUCH, 63, '0, 1'b0));
        send(make_req(OP_VICTIM, 0, '0, 1'b0));
        drain();

        // One frame, pinned: no victim; frame 1 is out of range.
        write_frames(CNT_BITS'(1));
        send(make_req(OP_PIN, 0, '0, 1'b1));
        send(make_req(OP_VICTIM, 0, '0, 1'b0));
        send(make_req(OP_RELEASE, 1, '0, 1'b0));
        drain();

        // Random phases: a new frame count each phase, written only once the
        // block has drained, so the sender pauses for every answer at each boundary.
        for (p = 0; p < 9; p++) begin
            case (p)
                0: cfg = CNT_BITS'(4);
                1: cfg = CNT_BITS'(1);
                2: cfg = CNT_BITS'(127);
                3: cfg = CNT_BITS'(0);
                4: cfg = CNT_BITS'(64);
                5: cfg = CNT_BITS'(2);
                default: begin
                    if ($urandom_range(0, 1) != 0)
                        cfg = CNT_BITS'($urandom_range(1, 16));
                    else
                        cfg = CNT_BITS'($urandom_range(17, 127));
                end
            endcase
            write_frames(cfg);
            lim = (cfg > NUM_FRAMES) ? NUM_FRAMES : int'(cfg);

            // Phase 4 runs flat out on both sides; the rest idle at random rates.
            if (p == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else begin
                send_idle_pct  = $urandom_range(0, 3) * 20;
                recv_stall_pct = $urandom_range(0, 3) * 20;
            end

            n = (p == 3) ? 30 : 85;
            for (k = 0; k < n; k++)
                send(random_req(lim));
            drain();
        end

        // Let any stray answer show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (answer_q.size() != 0)
            mismatches += answer_q.size();

        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #15000000;
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
